### design/lstf_pkg.sv
// shared types, constants and helpers of the sweep-with-tail frame generator
package lstf_pkg;

   // fixed widths of the stream fields
   localparam int DT_W       = 16;
   localparam int SPEED_W    = 8;
   localparam int COLOR_W    = 24;
   localparam int LUMA_W     = 8;
   localparam int FIRST_W    = 9;
   localparam int LANES      = 8;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 104;
   localparam int CSR_IDX_W  = 2;

   // register indexes of the control port
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TINT  = 2'd1;

   localparam logic [SPEED_W-1:0] SPEED_RESET = 8'd50;
   localparam logic [COLOR_W-1:0] TINT_RESET  = 24'hffffff;

   // speed 50 means one pass per second
   localparam int SPEED_UNIT = 50;

   // dt*speed fits 24 bits; the step is below 2^19 and the phase below 2^14,
   // so step plus phase fits 20 bits
   localparam int PROD_W = DT_W + SPEED_W;
   localparam int SUM_W  = 20;

   // head column fits 64 columns
   localparam int HEAD_W = 6;

   // tail lengths
   localparam int DIST_W = 4;
   localparam logic [DIST_W:0] TAIL_SHORT = 5'd8;
   localparam logic [DIST_W:0] TAIL_LONG  = 5'd16;
   localparam logic [LUMA_W-1:0] LUMA_TOP = 8'd255;

   typedef enum logic [2:0] {
      F_IDLE,
      F_MUL,
      F_STEP,
      F_SUM,
      F_PASS,
      F_PHASE,
      F_HEAD,
      F_PUSH
   } front_state_type;

   // one classified tick handed from front to back
   typedef struct packed {
      logic [HEAD_W-1:0] head;
      logic              long_tail;
      logic              wrapped;
   } job_type;

   // 255 - 240*d/tail; the tail is 8 or 16 so the step is 30 or 15
   function automatic logic [LUMA_W-1:0] luma_of(input logic [DIST_W-1:0] d,
                                                 input logic long_tail);
      logic [LUMA_W+1:0] drop;
      begin
         if (long_tail) begin
            drop = 10'(d) * 10'd15;
         end else begin
            drop = 10'(d) * 10'd30;
         end
         luma_of = LUMA_TOP - drop[LUMA_W-1:0];
      end
   endfunction

endpackage

### design/led_sweep_tail_frame_generator.sv
// top level of the sweep-with-tail frame generator
//
// req channel: one tick word per frame, elapsed milliseconds in tdata and the
//   button-held flag in tuser. the front end takes the tick, advances the sweep
//   phase by elapsed*speed/50 modulo one pass and finds the head column.
// rsp channel: one word per 8-pixel span, ceil(PIXELS/8) words per tick, in
//   pixel order; tlast marks the last span, tuser carries the wrap flag there.
// csr channel: index 0 is speed, index 1 is the tint color; always ready. the user
//   must write only while no tick is in flight; the block does not enforce it.
// front end: one tick at a time, a multiply, then the divisions by 50, by the
//   pass length and by ms per column as reciprocal multiplies.
// throughput: one span word per cycle while the receiver is ready; the span
//   engine's output rate sets the tick rate.
// a two-entry queue sits between front and back, so the next tick is worked
//   on while the current frame is still streaming out.
// reset: phase goes to zero, speed to 50, tint to white, all channels empty.
// receiver stall: the span word holds in the output register, the span engine
//   halts, and the queue and front end back up until ready returns.
module led_sweep_tail_frame_generator
   import lstf_pkg::*;
#(
   parameter int COLUMNS    = 40,
   parameter int PIXELS     = 480,
   parameter int MS_PER_COL = 25
)
(
   input  logic                  clock,
   input  logic                  reset,
   // tick words
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [15:0] elapsed_ms
   input  logic [0:0]            req_tuser,   // [0] button_held
   // span words
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [8:0] span_first_pixel, [32:9] span_color, [40:33] luma_p0 .. [96:89] luma_p7,
   // [103:97] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,   // last_span
   output logic [0:0]            rsp_tuser,   // [0] cycle_boundary
   // register writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [COLOR_W-1:0]    csr_wdata
);

   logic [SPEED_W-1:0] speed_ff;
   logic [COLOR_W-1:0] tint_ff;

   logic               job_push_valid, job_push_ready;
   job_type            job_push;
   logic               job_pop_valid, job_pop_ready;
   job_type            job_pop;

   logic [FIRST_W-1:0] span_first_pixel;
   logic [COLOR_W-1:0] span_color;
   logic [LUMA_W-1:0]  luma [LANES];
   logic               last_span;
   logic               cycle_boundary;

   // control registers, unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff <= SPEED_RESET;
         tint_ff  <= TINT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SPEED: speed_ff <= csr_wdata[SPEED_W-1:0];
            CSR_TINT:  tint_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   lstf_front #(
      .COLUMNS    (COLUMNS),
      .MS_PER_COL (MS_PER_COL)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .elapsed_ms  (req_tdata[DT_W-1:0]),
      .button_held (req_tuser[0]),
      .speed       (speed_ff),
      .job_valid   (job_push_valid),
      .job_ready   (job_push_ready),
      .job         (job_push)
   );

   lstf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (job_push_valid),
      .push_ready (job_push_ready),
      .push_job   (job_push),
      .pop_valid  (job_pop_valid),
      .pop_ready  (job_pop_ready),
      .pop_job    (job_pop)
   );

   lstf_back #(
      .COLUMNS (COLUMNS),
      .PIXELS  (PIXELS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .job_valid        (job_pop_valid),
      .job_ready        (job_pop_ready),
      .job              (job_pop),
      .tint_color       (tint_ff),
      .rsp_valid        (rsp_tvalid),
      .rsp_ready        (rsp_tready),
      .span_first_pixel (span_first_pixel),
      .span_color       (span_color),
      .luma             (luma),
      .last_span        (last_span),
      .cycle_boundary   (cycle_boundary)
   );

   // pack the span word, first field lowest
   assign rsp_tdata = {7'd0,
                       luma[7], luma[6], luma[5], luma[4],
                       luma[3], luma[2], luma[1], luma[0],
                       span_color, span_first_pixel};
   assign rsp_tlast    = last_span;
   assign rsp_tuser[0] = cycle_boundary;

endmodule

### design/lstf_div.sv
// division by a constant through a reciprocal multiply, registered quotient
module lstf_div #(
   parameter int IN_W    = 24,
   parameter int DIVISOR = 50
)
(
   input  logic            clock,
   input  logic            load,
   input  logic [IN_W-1:0] num,
   output logic [IN_W-1:0] quot
);

   // rounded-up reciprocal with a shift of IN_W + ceil(log2 d) is exact for any IN_W-bit value
   localparam int SHIFT   = IN_W + $clog2(DIVISOR);
   localparam int RECIP_W = IN_W + 1;
   localparam int MUL_W   = 2 * IN_W + 1;
   localparam longint unsigned RECIP_FULL =
      ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

   logic [MUL_W-1:0] prod;
   logic [IN_W-1:0]  quot_ff, quot_in;

   assign prod    = MUL_W'(num) * MUL_W'(RECIP);
   assign quot_in = IN_W'(prod >> SHIFT);

   always_ff @(posedge clock) begin
      if (load) begin
         quot_ff <= quot_in;
      end
   end

   assign quot = quot_ff;

endmodule

### design/lstf_front.sv
// tick front end: phase update, wrap detect and head column
module lstf_front
   import lstf_pkg::*;
#(
   parameter int COLUMNS    = 40,
   parameter int MS_PER_COL = 25
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [DT_W-1:0]    elapsed_ms,
   input  logic               button_held,
   input  logic [SPEED_W-1:0] speed,
   output logic               job_valid,
   input  logic               job_ready,
   output job_type            job
);

   localparam int PASS_MS = COLUMNS * MS_PER_COL;
   localparam int PHASE_W = $clog2(PASS_MS);

   front_state_type state_ff, state_in;

   logic [DT_W-1:0]    dt_ff;
   logic               held_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic [PHASE_W-1:0] phase_ff;
   logic               wrap_ff;

   logic               step_load, pass_load, head_load;
   logic [PROD_W-1:0]  step_q;
   logic [SUM_W-1:0]   pass_q;
   logic [PHASE_W-1:0] head_q;
   logic [SUM_W-1:0]   pass_rem;
   logic [PHASE_W-1:0] new_phase;

   // step = dt*speed/50
   lstf_div #(
      .IN_W    (PROD_W),
      .DIVISOR (SPEED_UNIT)
   ) u_div_step (
      .clock (clock),
      .load  (step_load),
      .num   (prod_ff),
      .quot  (step_q)
   );

   // whole passes in old phase plus step
   lstf_div #(
      .IN_W    (SUM_W),
      .DIVISOR (PASS_MS)
   ) u_div_pass (
      .clock (clock),
      .load  (pass_load),
      .num   (sum_ff),
      .quot  (pass_q)
   );

   // head column of the new phase
   lstf_div #(
      .IN_W    (PHASE_W),
      .DIVISOR (MS_PER_COL)
   ) u_div_head (
      .clock (clock),
      .load  (head_load),
      .num   (phase_ff),
      .quot  (head_q)
   );

   assign pass_rem  = sum_ff - SUM_W'(pass_q * SUM_W'(PASS_MS));
   assign new_phase = pass_rem[PHASE_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      job_valid = 1'b0;
      step_load = 1'b0;
      pass_load = 1'b0;
      head_load = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) state_in = F_MUL;
         end
         F_MUL: state_in = F_STEP;
         F_STEP: begin
            step_load = 1'b1;
            state_in  = F_SUM;
         end
         F_SUM: state_in = F_PASS;
         F_PASS: begin
            pass_load = 1'b1;
            state_in  = F_PHASE;
         end
         F_PHASE: state_in = F_HEAD;
         F_HEAD: begin
            head_load = 1'b1;
            state_in  = F_PUSH;
         end
         F_PUSH: begin
            job_valid = 1'b1;
            if (job_ready) state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else if (state_ff == F_PHASE) begin
         phase_ff <= new_phase;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == F_IDLE && req_valid) begin
         dt_ff   <= elapsed_ms;
         held_ff <= button_held;
      end
      if (state_ff == F_MUL) begin
         prod_ff <= PROD_W'(dt_ff) * PROD_W'(speed);
      end
      if (state_ff == F_SUM) begin
         // add the old phase to the step
         sum_ff <= SUM_W'(step_q) + SUM_W'(phase_ff);
      end
      if (state_ff == F_PHASE) begin
         wrap_ff <= new_phase < phase_ff;
      end
   end

   assign job.head      = HEAD_W'(head_q);
   assign job.long_tail = held_ff;
   assign job.wrapped   = wrap_ff;

endmodule

### design/lstf_queue.sv
// two-entry job queue between front and back
module lstf_queue
   import lstf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  job_type push_job,
   output logic    pop_valid,
   input  logic    pop_ready,
   output job_type pop_job
);

   job_type    entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       do_push, do_pop;

   assign push_ready = count_ff != 2'd2;
   assign pop_valid  = count_ff != 2'd0;
   assign pop_job    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= ~wr_ptr_ff;
         if (do_pop)  rd_ptr_ff <= ~rd_ptr_ff;
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_job;
   end

endmodule

### design/lstf_back.sv
// span engine: walks the frame into an output register, one 8-pixel span per cycle while not stalled
module lstf_back
   import lstf_pkg::*;
#(
   parameter int COLUMNS = 40,
   parameter int PIXELS  = 480
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   output logic               job_ready,
   input  job_type            job,
   input  logic [COLOR_W-1:0] tint_color,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [FIRST_W-1:0] span_first_pixel,
   output logic [COLOR_W-1:0] span_color,
   output logic [LUMA_W-1:0]  luma [LANES],
   output logic               last_span,
   output logic               cycle_boundary
);

   localparam int SPAN_COUNT = (PIXELS + 7) / 8;
   localparam int SPAN_W     = (SPAN_COUNT > 1) ? $clog2(SPAN_COUNT) : 1;
   localparam int PIX_W      = SPAN_W + 4;
   localparam int COL_W      = $clog2(COLUMNS);

   logic               active_ff;
   job_type            job_ff;
   logic [SPAN_W-1:0]  span_ff;
   logic [COL_W-1:0]   col_base_ff;

   logic               rsp_valid_ff;
   logic [FIRST_W-1:0] first_ff;
   logic [COLOR_W-1:0] color_ff;
   logic [LUMA_W-1:0]  luma_ff [LANES];
   logic               last_ff;
   logic               bound_ff;

   logic               advance, is_last, take_job;
   logic [COL_W:0]     next_base;
   logic [COL_W-1:0]   head;
   logic [PIX_W-1:0]   pix_base;
   logic [COL_W:0]     col_k  [LANES];
   logic [COL_W:0]     dist_k [LANES];
   logic [PIX_W-1:0]   pix_k  [LANES];
   logic [LUMA_W-1:0]  luma_k [LANES];
   logic [DIST_W:0]    tail_len;

   assign advance   = active_ff && (!rsp_valid_ff || rsp_ready);
   assign is_last   = span_ff == SPAN_W'(SPAN_COUNT - 1);
   assign take_job  = job_valid && (!active_ff || (advance && is_last));
   assign job_ready = take_job;

   assign head     = job_ff.head[COL_W-1:0];
   assign pix_base = PIX_W'({span_ff, 3'b000});
   assign tail_len = job_ff.long_tail ? TAIL_LONG : TAIL_SHORT;

   always_comb begin
      next_base = {1'b0, col_base_ff} + (COL_W+1)'(LANES);
      if (next_base >= (COL_W+1)'(COLUMNS)) begin
         next_base = next_base - (COL_W+1)'(COLUMNS);
      end
   end

   // per pixel: column, distance behind the head, luma
   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         col_k[k] = {1'b0, col_base_ff} + (COL_W+1)'(k);
         if (col_k[k] >= (COL_W+1)'(COLUMNS)) begin
            col_k[k] = col_k[k] - (COL_W+1)'(COLUMNS);
         end
         if ({1'b0, head} >= col_k[k]) begin
            dist_k[k] = {1'b0, head} - col_k[k];
         end else begin
            dist_k[k] = {1'b0, head} + (COL_W+1)'(COLUMNS) - col_k[k];
         end
         pix_k[k] = pix_base + PIX_W'(k);
         if (pix_k[k] >= PIX_W'(PIXELS)) begin
            luma_k[k] = '0;
         end else if (7'(dist_k[k]) < 7'(tail_len)) begin
            luma_k[k] = luma_of(dist_k[k][DIST_W-1:0], job_ff.long_tail);
         end else begin
            luma_k[k] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take_job) begin
            active_ff <= 1'b1;
         end else if (advance && is_last) begin
            active_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_job) begin
         job_ff      <= job;
         span_ff     <= '0;
         col_base_ff <= '0;
      end else if (advance) begin
         span_ff     <= span_ff + SPAN_W'(1);
         col_base_ff <= next_base[COL_W-1:0];
      end
      if (advance) begin
         first_ff <= FIRST_W'(pix_base);
         color_ff <= tint_color;
         luma_ff  <= luma_k;
         last_ff  <= is_last;
         bound_ff <= is_last && job_ff.wrapped;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign span_first_pixel = first_ff;
   assign span_color       = color_ff;
   assign luma             = luma_ff;
   assign last_span        = last_ff;
   assign cycle_boundary   = bound_ff;

endmodule

### design/lstf_checker.sv
// port-level checks of the frame generator and their binding
module lstf_checker
   import lstf_pkg::*;
#(
   parameter int PIXELS = 480
)
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast,
   input logic [0:0]            rsp_tuser
);

   localparam int LAST_FIRST = ((PIXELS + 7) / 8 - 1) * 8;

   // a stalled span word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("span word changed while stalled");

   // wrap flag only on the last span
   a_wrap_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast)
      else $error("wrap flag outside last span");

   // last span starts at the last span position of the frame
   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[FIRST_W-1:0] == FIRST_W'(LAST_FIRST))
      else $error("last span at wrong pixel");

   // front end never takes ticks back to back
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("tick taken on consecutive cycles");

   // nothing leaves right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("span word valid after reset");

endmodule

bind led_sweep_tail_frame_generator lstf_checker #(
   .PIXELS (PIXELS)
) u_lstf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
